>>> sv/image_fnv1a64_fingerprint_unit_macros.svh
// Assertion macros for the image fingerprint unit checker.
// Used by the checker file only; no other dependencies.
`ifndef IMAGE_FNV1A64_FINGERPRINT_UNIT_MACROS_SVH
`define IMAGE_FNV1A64_FINGERPRINT_UNIT_MACROS_SVH

// clocked check, off while reset is asserted
`define IMGFNV_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// clocked check that also holds through reset
`define IMGFNV_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/imgfnv_pkg.sv
// Shared types, constants and the FNV-1a mix function for the fingerprint unit.
// No dependencies.
`default_nettype none
package imgfnv_pkg;

    localparam int DIM_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME  = 64'h0000_0100_0000_01B3;

    localparam int HDR_STEPS = 17;
    localparam int STEP_BITS = 5;

    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FORMAT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE   = 3'd4;

    localparam logic [2:0] MAX_CHANNELS = 3'd4;

    typedef enum logic [0:0] {
        HDR_IDLE,
        HDR_RUN
    } hdr_state_t;

    // one queued work item for the hash engine
    typedef struct packed {
        logic       start;  // load header hash before mixing
        logic       mix;    // mix data byte
        logic       last;   // emit hash after this entry
        logic       err;    // emit error result
        logic [7:0] data;
    } qent_t;

    // h ^= b; h *= prime, prime = 2^40 + 0x1b3 as shift-add
    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage
`default_nettype wire

>>> sv/imgfnv_hdr.sv
// Header hash precompute: mixes width/height bytes interleaved, then the format byte.
// Depends on imgfnv_pkg.
`default_nettype none
module imgfnv_hdr #(
    parameter int DIM_BITS = imgfnv_pkg::DIM_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                restart,
    input  wire logic [DIM_BITS-1:0] width,
    input  wire logic [DIM_BITS-1:0] height,
    input  wire logic [7:0]          format,
    output logic                     busy,
    output logic [63:0]              header_hash
);

    imgfnv_pkg::hdr_state_t state_reg, state_next;
    logic [imgfnv_pkg::STEP_BITS-1:0] step_reg;
    logic [63:0] hash_reg;
    logic [63:0] w_ext, h_ext;
    logic [7:0]  mix_byte;

    assign w_ext = {{(64-DIM_BITS){1'b0}}, width};
    assign h_ext = {{(64-DIM_BITS){1'b0}}, height};

    always_comb begin
        if (step_reg[4]) begin
            mix_byte = format;
        end else if (step_reg[0]) begin
            mix_byte = h_ext[{step_reg[3:1], 3'b000} +: 8];
        end else begin
            mix_byte = w_ext[{step_reg[3:1], 3'b000} +: 8];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            imgfnv_pkg::HDR_IDLE: begin
                if (restart) state_next = imgfnv_pkg::HDR_RUN;
            end
            imgfnv_pkg::HDR_RUN: begin
                if (!restart &&
                    step_reg == imgfnv_pkg::STEP_BITS'(imgfnv_pkg::HDR_STEPS - 1)) begin
                    state_next = imgfnv_pkg::HDR_IDLE;
                end
            end
            default: state_next = imgfnv_pkg::HDR_RUN;
        endcase
    end

    always_comb begin
        case (state_reg)
            imgfnv_pkg::HDR_RUN: busy = 1'b1;
            default:             busy = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imgfnv_pkg::HDR_RUN;
            step_reg  <= '0;
            hash_reg  <= imgfnv_pkg::FNV_OFFSET;
        end else begin
            state_reg <= state_next;
            if (restart) begin
                step_reg <= '0;
                hash_reg <= imgfnv_pkg::FNV_OFFSET;
            end else if (busy) begin
                step_reg <= step_reg + 1'b1;
                hash_reg <= imgfnv_pkg::fnv_mix(hash_reg, mix_byte);
            end
        end
    end

    assign header_hash = hash_reg;

endmodule
`default_nettype wire

>>> sv/imgfnv_front.sv
// Front end: configuration registers, row/column tracking and byte classification.
// Depends on imgfnv_pkg; feeds imgfnv_queue.
`default_nettype none
module imgfnv_front #(
    parameter int DIM_BITS = imgfnv_pkg::DIM_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [imgfnv_pkg::CFG_IDX_BITS-1:0] cfg_addr,
    input  wire logic [DIM_BITS+1:0]                 cfg_wr_data,
    input  wire logic                                in_valid,
    input  wire logic [7:0]                          in_data,
    input  wire logic                                in_first,
    output logic                                     in_ready,
    input  wire logic                                q_full,
    input  wire logic                                hdr_busy,
    output logic                                     q_push,
    output imgfnv_pkg::qent_t                        q_ent,
    output logic [DIM_BITS-1:0]                      width,
    output logic [DIM_BITS-1:0]                      height,
    output logic [7:0]                               format
);

    localparam int STRIDE_BITS = DIM_BITS + 2;
    localparam int RB_BITS     = DIM_BITS + 3;

    logic [DIM_BITS-1:0]    width_reg, height_reg;
    logic [7:0]             format_reg;
    logic [2:0]             chan_reg;
    logic [STRIDE_BITS-1:0] stride_reg;
    logic [RB_BITS-1:0]     line_len, line_len_reg;
    logic                   shape_bad, shape_bad_reg;

    logic                   active_reg, active_next;
    logic [STRIDE_BITS-1:0] col_reg, col_next, col_cur;
    logic [DIM_BITS-1:0]    row_reg, row_next, row_cur;
    logic                   accept, act, start, err, mix, last, row_wrap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_BITS'(1);
            height_reg <= DIM_BITS'(1);
            format_reg <= '0;
            chan_reg   <= 3'd1;
            stride_reg <= STRIDE_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                imgfnv_pkg::CFG_WIDTH:    width_reg  <= cfg_wr_data[DIM_BITS-1:0];
                imgfnv_pkg::CFG_HEIGHT:   height_reg <= cfg_wr_data[DIM_BITS-1:0];
                imgfnv_pkg::CFG_FORMAT:   format_reg <= cfg_wr_data[7:0];
                imgfnv_pkg::CFG_CHANNELS: chan_reg   <= cfg_wr_data[2:0];
                imgfnv_pkg::CFG_STRIDE:   stride_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        line_len  = RB_BITS'(width_reg) * RB_BITS'(chan_reg);
        shape_bad = (width_reg == '0) || (height_reg == '0) || (chan_reg == 3'd0) ||
                    (chan_reg > imgfnv_pkg::MAX_CHANNELS) ||
                    (RB_BITS'(stride_reg) < line_len);
    end

    // settles while the header precompute holds the input off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg  <= RB_BITS'(1);
            shape_bad_reg <= 1'b0;
        end else begin
            line_len_reg  <= line_len;
            shape_bad_reg <= shape_bad;
        end
    end

    assign in_ready = !q_full && !hdr_busy;
    assign accept   = in_valid && in_ready;

    always_comb begin
        start    = in_first && !shape_bad_reg;
        err      = in_first && shape_bad_reg;
        act      = in_first ? !shape_bad_reg : active_reg;
        col_cur  = in_first ? '0 : col_reg;
        row_cur  = in_first ? '0 : row_reg;
        mix      = act && (RB_BITS'(col_cur) < line_len_reg);
        last     = act && ((DIM_BITS+1)'(row_cur) + 1'b1 >= (DIM_BITS+1)'(height_reg)) &&
                   (RB_BITS'(col_cur) + 1'b1 >= line_len_reg);
        row_wrap = (STRIDE_BITS+1)'(col_cur) + 1'b1 >= (STRIDE_BITS+1)'(stride_reg);

        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (accept) begin
            if (err || last) begin
                active_next = 1'b0;
                col_next    = '0;
                row_next    = '0;
            end else if (act) begin
                active_next = 1'b1;
                if (row_wrap) begin
                    col_next = '0;
                    row_next = row_cur + 1'b1;
                end else begin
                    col_next = col_cur + 1'b1;
                    row_next = row_cur;
                end
            end
        end

        q_push     = accept && (err || start || mix || last);
        q_ent.start = start;
        q_ent.mix   = mix;
        q_ent.last  = last;
        q_ent.err   = err;
        q_ent.data  = in_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            active_reg <= active_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign width  = width_reg;
    assign height = height_reg;
    assign format = format_reg;

endmodule
`default_nettype wire

>>> sv/imgfnv_queue.sv
// Small FIFO of classified work items between front end and hash engine.
// Depends on imgfnv_pkg.
`default_nettype none
module imgfnv_queue #(
    parameter int DEPTH = imgfnv_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire imgfnv_pkg::qent_t  push_ent,
    input  wire logic               pop,
    output imgfnv_pkg::qent_t       head,
    output logic                    empty,
    output logic                    full
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    imgfnv_pkg::qent_t   store [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) store[wr_ptr_reg] <= push_ent;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/imgfnv_back.sv
// Hash engine: at most one FNV-1a mix per entry, result held in an output register.
// Depends on imgfnv_pkg; drains imgfnv_queue.
`default_nettype none
module imgfnv_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    input  wire imgfnv_pkg::qent_t  q_head,
    output logic                    q_pop,
    input  wire logic [63:0]        header_hash,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic [63:0]             m_tdata,
    output logic                    m_tuser
);

    logic [63:0] run_reg, run_next;
    logic [63:0] h0;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_hash_reg, out_hash_next;
    logic        out_err_reg, out_err_next;
    logic        emits, out_free;

    always_comb begin
        h0       = q_head.start ? header_hash : run_reg;
        run_next = q_head.mix ? imgfnv_pkg::fnv_mix(h0, q_head.data) : h0;
        emits    = q_head.last || q_head.err;
        out_free = !out_valid_reg || m_tready;
        q_pop    = !q_empty && (!emits || out_free);

        out_valid_next = out_valid_reg && !m_tready;
        out_hash_next  = out_hash_reg;
        out_err_next   = out_err_reg;
        if (q_pop && emits) begin
            out_valid_next = 1'b1;
            out_hash_next  = q_head.err ? '0 : run_next;
            out_err_next   = q_head.err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg       <= imgfnv_pkg::FNV_OFFSET;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) run_reg <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_hash_reg <= out_hash_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;
    assign m_tuser  = out_err_reg;

endmodule
`default_nettype wire

>>> sv/image_fnv1a64_fingerprint_unit.sv
// Top level of the image fingerprint unit: front end, work queue, hash engine, header.
// Depends on imgfnv_pkg, imgfnv_front, imgfnv_queue, imgfnv_back, imgfnv_hdr.
//
//   channel  dir  tdata                 tuser
//   s_       in   [7:0] data_byte       [0] first_byte
//   m_       out  [63:0] fingerprint    [0] status (1 = bad shape)
//   cfg_     in   wr_data, reg by addr  -
//
// While the output is drained: one byte per cycle in, one FNV-1a mix per cycle in the engine.
// The completing beat is written into the queue, then the engine registers its result.
// After reset and after every config write the header hash is recomputed with s_tready low.
// A stalled output fills the 4-entry queue, then s_tready drops.
`default_nettype none
module image_fnv1a64_fingerprint_unit #(
    parameter int DIM_BITS    = imgfnv_pkg::DIM_BITS_DEF,
    parameter int QUEUE_DEPTH = imgfnv_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // data_byte
    input  wire logic                                s_tuser,   // first_byte
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [63:0]                              m_tdata,   // fingerprint
    output logic                                     m_tuser,   // status
    input  wire logic                                cfg_wr_en,
    input  wire logic [imgfnv_pkg::CFG_IDX_BITS-1:0] cfg_addr,
    input  wire logic [DIM_BITS+1:0]                 cfg_wr_data
);

    imgfnv_pkg::qent_t   push_ent, head_ent;
    logic                q_push, q_pop, q_empty, q_full;
    logic                hdr_busy;
    logic [63:0]         header_hash;
    logic [DIM_BITS-1:0] width, height;
    logic [7:0]          format;

    imgfnv_front #(
        .DIM_BITS(DIM_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_data     (s_tdata),
        .in_first    (s_tuser),
        .in_ready    (s_tready),
        .q_full      (q_full),
        .hdr_busy    (hdr_busy),
        .q_push      (q_push),
        .q_ent       (push_ent),
        .width       (width),
        .height      (height),
        .format      (format)
    );

    imgfnv_hdr #(
        .DIM_BITS(DIM_BITS)
    ) u_hdr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .restart     (cfg_wr_en),
        .width       (width),
        .height      (height),
        .format      (format),
        .busy        (hdr_busy),
        .header_hash (header_hash)
    );

    imgfnv_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_ent (push_ent),
        .pop      (q_pop),
        .head     (head_ent),
        .empty    (q_empty),
        .full     (q_full)
    );

    imgfnv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (head_ent),
        .q_pop       (q_pop),
        .header_hash (header_hash),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire

>>> sv/imgfnv_checker.sv
// Port-level checker for the image fingerprint unit, bound to the top level.
// Depends on image_fnv1a64_fingerprint_unit_macros.svh.
`default_nettype none
`include "image_fnv1a64_fingerprint_unit_macros.svh"
module imgfnv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        cfg_wr_en
);

    `IMGFNV_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result beat changed while stalled")
    `IMGFNV_ASSERT(a_err_zero, aclk, aresetn,
        m_tvalid && m_tuser |-> m_tdata == 64'd0,
        "error result with nonzero fingerprint")
    `IMGFNV_ASSERT_NR(a_rst_hdr, aclk,
        !aresetn |=> !s_tready && !m_tvalid,
        "input open or output valid right after reset")
    `IMGFNV_ASSERT_NR(a_cfg_hdr, aclk,
        cfg_wr_en |=> !s_tready,
        "input open during header refresh")

endmodule

bind image_fnv1a64_fingerprint_unit imgfnv_checker u_imgfnv_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en)
);
`default_nettype wire

>>> tb/tb_image_fnv1a64_fingerprint_unit.sv
// Self-checking testbench for image_fnv1a64_fingerprint_unit: streams image bytes,
// predicts each 64-bit FNV-1a fingerprint or shape error and checks every result beat.
// Depends on imgfnv_pkg and the unit's RTL.
`default_nettype none
module tb_image_fnv1a64_fingerprint_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_SHAPE = 1'b1;
    localparam int   IDLE_LIMIT       = 4000;
    localparam int   SETTLE_CYCLES    = 16;

    typedef struct packed {
        logic [63:0] fingerprint;
        logic        status;
    } fp_result_t;

    logic                                aclk;
    logic                                aresetn     = 1'b0;
    logic                                s_tvalid    = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata     = 8'd0;   // data_byte
    logic                                s_tuser     = 1'b0;   // first_byte
    logic                                m_tvalid;
    logic                                m_tready    = 1'b0;
    logic [63:0]                         m_tdata;              // fingerprint
    logic                                m_tuser;              // status
    logic                                cfg_wr_en   = 1'b0;
    logic [imgfnv_pkg::CFG_IDX_BITS-1:0] cfg_addr    = imgfnv_pkg::CFG_WIDTH;
    logic [17:0]                         cfg_wr_data = 18'd0;

    // predicted unit state
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [7:0]  img_format;
    logic [2:0]  img_channels;
    logic [17:0] img_stride;
    logic [63:0] run_hash;
    logic [63:0] hdr_hash;
    logic [17:0] col_count;
    logic [15:0] row_count;
    logic        img_active;

    fp_result_t fingerprint_q[$];
    fp_result_t want;
    int         fail_count    = 0;
    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    int         live_beats    = 0;
    int         quiet_cycles  = 0;

    image_fnv1a64_fingerprint_unit #(
        .DIM_BITS(16)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * imgfnv_pkg::FNV_PRIME;
    endfunction

    // width and height bytes interleaved low first, then the format byte
    function automatic void refresh_header();
        logic [63:0] h;
        logic [63:0] w;
        logic [63:0] ht;
        h  = imgfnv_pkg::FNV_OFFSET;
        w  = {48'd0, img_width};
        ht = {48'd0, img_height};
        for (int k = 0; k < 8; k++) begin
            h  = fnv_step(h, w[7:0]);
            h  = fnv_step(h, ht[7:0]);
            w  = w >> 8;
            ht = ht >> 8;
        end
        hdr_hash = fnv_step(h, img_format);
    endfunction

    function automatic int unsigned row_len();
        return 32'(img_width) * 32'(img_channels);
    endfunction

    function automatic logic shape_ok();
        return img_width != 16'd0 && img_height != 16'd0 && img_channels != 3'd0 &&
               img_channels <= imgfnv_pkg::MAX_CHANNELS && 32'(img_stride) >= row_len();
    endfunction

    function automatic int unsigned image_len();
        return (32'(img_height) - 32'd1) * 32'(img_stride) + row_len();
    endfunction

    function automatic void expect_result(input fp_result_t r);
        fingerprint_q.insert(fingerprint_q.size(), r);
    endfunction

    task automatic fingerprint_beat(input logic [7:0] b, input logic first);
        int unsigned rlen;
        fp_result_t  r;
        rlen = row_len();
        if (first && !shape_ok()) begin
            img_active    = 1'b0;
            col_count     = '0;
            row_count     = '0;
            r.fingerprint = 64'd0;
            r.status      = STATUS_BAD_SHAPE;
            expect_result(r);
        end else begin
            if (first) begin
                run_hash   = hdr_hash;
                col_count  = '0;
                row_count  = '0;
                img_active = 1'b1;
            end
            if (img_active) begin
                if (32'(col_count) < rlen)
                    run_hash = fnv_step(run_hash, b);
                if (32'(row_count) + 32'd1 >= 32'(img_height) &&
                    32'(col_count) + 32'd1 >= rlen) begin
                    img_active    = 1'b0;
                    col_count     = '0;
                    row_count     = '0;
                    r.fingerprint = run_hash;
                    r.status      = STATUS_OK;
                    expect_result(r);
                end else if (32'(col_count) + 32'd1 >= 32'(img_stride)) begin
                    col_count = '0;
                    row_count = row_count + 16'd1;
                end else begin
                    col_count = col_count + 18'd1;
                end
            end
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (first || img_active)
            live_beats++;
        fingerprint_beat(b, first);
    endtask

    task automatic send_image(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_beat(8'($urandom_range(255)), i == 0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (fingerprint_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [imgfnv_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [17:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            imgfnv_pkg::CFG_WIDTH:    img_width    = val[15:0];
            imgfnv_pkg::CFG_HEIGHT:   img_height   = val[15:0];
            imgfnv_pkg::CFG_FORMAT:   img_format   = val[7:0];
            imgfnv_pkg::CFG_CHANNELS: img_channels = val[2:0];
            imgfnv_pkg::CFG_STRIDE:   img_stride   = val;
            default: ;
        endcase
        refresh_header();
    endtask

    // closes any open image, lets the unit go quiet, then writes every register
    task automatic apply_config(input logic [15:0] w, input logic [15:0] h,
                                input logic [7:0] fmt, input logic [2:0] ch,
                                input logic [17:0] stride);
        while (img_active)
            send_beat(8'($urandom_range(255)), 1'b0);
        settle();
        write_reg(imgfnv_pkg::CFG_WIDTH, {2'd0, w});
        write_reg(imgfnv_pkg::CFG_HEIGHT, {2'd0, h});
        write_reg(imgfnv_pkg::CFG_FORMAT, {10'd0, fmt});
        write_reg(imgfnv_pkg::CFG_CHANNELS, {15'd0, ch});
        write_reg(imgfnv_pkg::CFG_STRIDE, stride);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_default_header();
        send_beat(8'h5A, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
    endtask

    task automatic test_row_padding();
        apply_config(16'd2, 16'd2, 8'hA5, 3'd2, 18'd6);
        send_image(image_len());
    endtask

    task automatic test_restart();
        apply_config(16'd3, 16'd1, 8'h01, 3'd1, 18'd3);
        send_beat(8'h11, 1'b1);
        send_beat(8'h22, 1'b0);
        send_image(image_len());
    endtask

    task automatic test_bad_shapes();
        apply_config(16'd0, 16'd1, 8'h10, 3'd1, 18'd1);
        send_beat(8'h01, 1'b1);
        send_beat(8'h02, 1'b0);
        apply_config(16'd1, 16'd0, 8'h20, 3'd1, 18'd1);
        send_beat(8'h03, 1'b1);
        apply_config(16'd2, 16'd2, 8'h30, 3'd0, 18'd4);
        send_beat(8'h04, 1'b1);
        apply_config(16'd2, 16'd2, 8'h40, 3'd5, 18'd20);
        send_beat(8'h05, 1'b1);
        apply_config(16'd1, 16'd1, 8'h50, 3'd7, 18'd20);
        send_beat(8'h06, 1'b1);
        apply_config(16'd4, 16'd1, 8'h60, 3'd3, 18'd11);
        send_beat(8'h07, 1'b1);
    endtask

    task automatic test_register_extremes();
        apply_config(16'hFFFF, 16'hFFFF, 8'hFF, 3'd4, 18'd1000);
        send_beat(8'h80, 1'b1);
        apply_config(16'd2, 16'd1, 8'hFF, 3'd4, 18'h3FFFF);
        send_image(image_len());
        apply_config(16'd1, 16'd1, 8'h00, 3'd1, 18'd1);
        send_image(image_len());
    endtask

    task automatic test_two_byte_dims();
        apply_config(16'h0101, 16'd1, 8'h3C, 3'd1, 18'h00101);
        send_image(image_len());
        apply_config(16'd1, 16'h0102, 8'hC3, 3'd1, 18'd1);
        send_image(image_len());
    endtask

    task automatic test_random_images(input int quota, input int src_pct, input int snk_pct);
        int unsigned w;
        int unsigned h;
        int unsigned ch;
        int unsigned stride;
        int unsigned rlen;
        int unsigned len;
        int          pick;
        int          start;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start         = live_beats;
        while (live_beats - start < quota) begin
            pick = $urandom_range(19);
            w    = $urandom_range(1, 6);
            h    = $urandom_range(1, 4);
            ch   = $urandom_range(1, 4);
            if (pick == 0) begin
                w = $urandom_range(7, 40);
            end else if (pick == 1) begin
                h  = $urandom_range(5, 40);
                w  = 1;
                ch = 1;
            end else if (pick == 2) begin
                ch = $urandom_range(1) ? 0 : $urandom_range(5, 7);
            end
            rlen   = w * ch;
            stride = rlen + $urandom_range(0, 3);
            if (pick == 3 && rlen > 1)
                stride = $urandom_range(1, rlen - 1);
            if (stride == 0)
                stride = $urandom_range(1, 4);
            apply_config(16'(w), 16'(h), 8'($urandom_range(255)), 3'(ch), 18'(stride));
            repeat ($urandom_range(2, 6)) begin
                pick = $urandom_range(9);
                len  = image_len();
                if (pick == 0)
                    send_beat(8'($urandom_range(255)), 1'b0);
                else if (!shape_ok())
                    send_beat(8'($urandom_range(255)), 1'b1);
                else if (pick == 1 && len > 1)
                    send_image($urandom_range(1, len - 1));
                else
                    send_image(len);
            end
        end
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (fingerprint_q.size() == 0) begin
                $error("unexpected result beat: fingerprint %h status %0d", m_tdata, m_tuser);
                fail_count = fail_count + 1;
            end else begin
                want = fingerprint_q.pop_front();
                if (m_tdata !== want.fingerprint) begin
                    $error("fingerprint mismatch: expected %h, actual %h",
                           want.fingerprint, m_tdata);
                    fail_count = fail_count + 1;
                end
                if (m_tuser !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        img_width    = 16'd1;
        img_height   = 16'd1;
        img_format   = 8'd0;
        img_channels = 3'd1;
        img_stride   = 18'd1;
        run_hash     = imgfnv_pkg::FNV_OFFSET;
        col_count    = '0;
        row_count    = '0;
        img_active   = 1'b0;
        refresh_header();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 31;
        snk_stall_pct = 31;
        test_default_header();
        test_row_padding();
        test_restart();
        test_bad_shapes();
        test_register_extremes();

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        test_two_byte_dims();

        test_random_images(170, 0, 0);
        test_random_images(170, 56, 0);
        test_random_images(170, 0, 56);
        test_random_images(170, 31, 31);

        settle();
        if (fail_count == 0 && fingerprint_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
